FILE: src/sdm_pkg.sv
// ---------------------------------------------------------------------------
// sdm_pkg: shared types and constants of the solenoid driver
// Operation codes, vector widths, register map and the configuration bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package sdm_pkg;

	localparam int unsigned VecW    = 25;
	localparam int unsigned NormW   = 16;
	localparam int unsigned SpecW   = 8;
	localparam int unsigned SpecLsb = 16;
	localparam int unsigned OpW     = 3;
	localparam int unsigned DataW   = 8;
	localparam int unsigned IdxW    = 3;
	localparam int unsigned MuxNumW = 5;
	localparam int unsigned AddrW   = 4;
	localparam int unsigned PdataW  = 32;

	localparam logic [VecW-1:0] KeepSpecial = 25'h1ff0000;
	localparam logic [VecW-1:0] KeepHigh    = 25'h1ffff00;
	localparam logic [VecW-1:0] GameOnBit   = 25'h1000000;
	localparam logic [MuxNumW-1:0] MuxNone  = 5'd0;
	localparam logic [MuxNumW-1:0] MuxBits  = 5'd25;

	typedef enum logic [OpW-1:0] {
		OP_LOW_BYTE    = 3'd0,
		OP_HIGH_BYTE   = 3'd1,
		OP_SPEC_LINE   = 3'd2,
		OP_SPEC_ENABLE = 3'd3,
		OP_FRAME_TICK  = 3'd4,
		OP_DIRECT_LOW  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		REG_ALT_MODE  = 2'd0,
		REG_MUX_SOL   = 2'd1,
		REG_MUX_MASK  = 2'd2,
		REG_SW_MASK   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic               alt_mode;
		logic [MuxNumW-1:0] mux_sol;
		logic [NormW-1:0]   mux_mask;
		logic [SpecW-1:0]   sw_mask;
	} cfg_t;

endpackage

`default_nettype wire

FILE: src/sdm_cfg.sv
// ---------------------------------------------------------------------------
// sdm_cfg: configuration registers
// APB-style register file holding mode, mux selection and masks.
// ---------------------------------------------------------------------------
`default_nettype none

module sdm_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sdm_pkg::AddrW-1:0]    paddr,
	input  wire logic [sdm_pkg::PdataW-1:0]   pwdata,
	output logic      [sdm_pkg::PdataW-1:0]   prdata,
	output logic                              pready,
	output sdm_pkg::cfg_t                     cfg
);
	import sdm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_ALT_MODE: cfg_q.alt_mode <= pwdata[0];
				REG_MUX_SOL:  cfg_q.mux_sol  <= pwdata[MuxNumW-1:0];
				REG_MUX_MASK: cfg_q.mux_mask <= pwdata[NormW-1:0];
				REG_SW_MASK:  cfg_q.sw_mask  <= pwdata[SpecW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ALT_MODE: prdata[0]             = cfg_q.alt_mode;
			REG_MUX_SOL:  prdata[MuxNumW-1:0]   = cfg_q.mux_sol;
			REG_MUX_MASK: prdata[NormW-1:0]     = cfg_q.mux_mask;
			REG_SW_MASK:  prdata[SpecW-1:0]     = cfg_q.sw_mask;
			default:      prdata                = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/sdm_core.sv
// ---------------------------------------------------------------------------
// sdm_core: solenoid state and per-transaction update
// Holds the byte latches, pulsed vector, frame accumulator, history and
// custom latch; computes the next state of one input transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module sdm_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sdm_pkg::cfg_t                cfg,
	input  wire logic                         take,
	input  wire logic [sdm_pkg::OpW-1:0]      op,
	input  wire logic [sdm_pkg::DataW-1:0]    data,
	input  wire logic [sdm_pkg::IdxW-1:0]     line_index,
	input  wire logic [sdm_pkg::SpecW-1:0]    trigger_switches,
	output logic      [sdm_pkg::VecW-1:0]     smoothed_nxt,
	output logic      [sdm_pkg::VecW-1:0]     pulsed_nxt,
	output logic      [sdm_pkg::NormW-1:0]    custom_nxt
);
	import sdm_pkg::*;

	logic [DataW-1:0] low_q, high_q, low_nxt, high_nxt;
	logic [VecW-1:0]  pulsed_q, acc_q, acc_nxt, hist0_q, hist1_q, hist0_nxt, hist1_nxt;
	logic [VecW-1:0]  smooth_q;
	logic             parity_q, parity_nxt, spec_en_q, spec_en_nxt;
	logic [NormW-1:0] custom_q;

	logic [VecW-1:0]    rebuilt, shifted, mux_clr, line_bit;
	logic [DataW-1:0]   rb_low, rb_high;
	logic [MuxNumW-1:0] mux_pos;
	logic               do_rebuild, mux_sel, line_on, gate_on;

	// Rebuild operands: the byte being written replaces its latched copy.
	assign rb_low  = (op_t'(op) == OP_LOW_BYTE)  ? data : low_q;
	assign rb_high = (op_t'(op) == OP_HIGH_BYTE) ? data : high_q;
	assign rebuilt = (pulsed_q & KeepSpecial) | {{(VecW-2*DataW){1'b0}}, rb_high, rb_low};
	assign mux_pos = cfg.mux_sol - 5'd1;
	assign shifted = rebuilt >> mux_pos;
	// A mux number beyond the vector selects a bit that reads as zero.
	assign mux_sel = (cfg.mux_sol != MuxNone) && (mux_pos < MuxBits) && shifted[0];
	assign mux_clr = {{(VecW-NormW){1'b0}}, cfg.mux_mask};

	assign line_bit = {{(VecW-SpecLsb-SpecW){1'b0}}, (SpecW'(1) << line_index),
		{SpecLsb{1'b0}}};
	assign line_on  = cfg.alt_mode ? data[0] : (spec_en_q & ~data[0]);
	assign gate_on  = cfg.alt_mode | spec_en_q;

	always_comb begin
		low_nxt     = low_q;
		high_nxt    = high_q;
		pulsed_nxt  = pulsed_q;
		acc_nxt     = acc_q;
		hist0_nxt   = hist0_q;
		hist1_nxt   = hist1_q;
		smoothed_nxt = smooth_q;
		parity_nxt  = parity_q;
		spec_en_nxt = spec_en_q;
		custom_nxt  = custom_q;
		do_rebuild  = 1'b0;
		case (op_t'(op))
			OP_LOW_BYTE: begin
				do_rebuild = (data != low_q);
				low_nxt    = data;
			end
			OP_HIGH_BYTE: begin
				do_rebuild = (data != high_q);
				high_nxt   = data;
			end
			OP_SPEC_LINE: begin
				if (line_on) begin
					pulsed_nxt = pulsed_q | line_bit;
					acc_nxt    = acc_q | line_bit;
				end else begin
					pulsed_nxt = pulsed_q & ~line_bit;
				end
			end
			OP_SPEC_ENABLE: spec_en_nxt = data[0];
			OP_FRAME_TICK: begin
				parity_nxt = ~parity_q;
				acc_nxt    = acc_q;
				if (gate_on) begin
					acc_nxt = acc_q | GameOnBit |
						{1'b0, (trigger_switches & cfg.sw_mask), {SpecLsb{1'b0}}};
				end
				if (parity_nxt) begin
					hist1_nxt = acc_nxt;
				end else begin
					hist0_nxt = acc_nxt;
				end
				smoothed_nxt = hist0_nxt | hist1_nxt;
				acc_nxt      = pulsed_q;
			end
			OP_DIRECT_LOW: begin
				pulsed_nxt = (pulsed_q & KeepHigh) | {{(VecW-DataW){1'b0}}, data};
				acc_nxt    = acc_q | {{(VecW-DataW){1'b0}}, data};
			end
			default: ;
		endcase
		if (do_rebuild) begin
			pulsed_nxt = rebuilt;
			if (cfg.mux_sol != MuxNone) begin
				if (mux_sel) begin
					custom_nxt = rebuilt[NormW-1:0] & cfg.mux_mask;
					pulsed_nxt = rebuilt & ~mux_clr;
				end else begin
					custom_nxt = '0;
				end
			end
			acc_nxt = acc_q | pulsed_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q     <= '0;
			high_q    <= '0;
			pulsed_q  <= '0;
			acc_q     <= '0;
			hist0_q   <= '0;
			hist1_q   <= '0;
			smooth_q  <= '0;
			parity_q  <= 1'b0;
			spec_en_q <= 1'b0;
			custom_q  <= '0;
		end else if (take) begin
			low_q     <= low_nxt;
			high_q    <= high_nxt;
			pulsed_q  <= pulsed_nxt;
			acc_q     <= acc_nxt;
			hist0_q   <= hist0_nxt;
			hist1_q   <= hist1_nxt;
			smooth_q  <= smoothed_nxt;
			parity_q  <= parity_nxt;
			spec_en_q <= spec_en_nxt;
			custom_q  <= custom_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: src/solenoid_driver_with_mux_smoothing.sv
// ---------------------------------------------------------------------------
// solenoid_driver_with_mux_smoothing: solenoid driver top level
// Byte, special-line and frame-tick transactions update a 25-bit solenoid
// vector with mux diversion and two-frame smoothing; one result per input.
// ---------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_ready     | op, data, line_index, trigger_switches
//  out     | out_valid / out_ready   | smoothed_solenoids, pulsed_solenoids,
//          |                         | custom_solenoids
//  cfg     | psel / penable / pready | paddr, pwrite, pwdata, prdata
//
// Each input transaction updates the state in the cycle it is accepted and its
// result appears in the output register the next cycle: one transaction per
// cycle unless the output stalls. in_ready is high while the output register is
// empty or being emptied, so a stalled output holds one result and stops input.
// Reset clears all but the output data registers; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module solenoid_driver_with_mux_smoothing (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [sdm_pkg::OpW-1:0]      op,
	input  wire logic [sdm_pkg::DataW-1:0]    data,
	input  wire logic [sdm_pkg::IdxW-1:0]     line_index,
	input  wire logic [sdm_pkg::SpecW-1:0]    trigger_switches,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [sdm_pkg::VecW-1:0]     smoothed_solenoids,
	output logic      [sdm_pkg::VecW-1:0]     pulsed_solenoids,
	output logic      [sdm_pkg::NormW-1:0]    custom_solenoids,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sdm_pkg::AddrW-1:0]    paddr,
	input  wire logic [sdm_pkg::PdataW-1:0]   pwdata,
	output logic      [sdm_pkg::PdataW-1:0]   prdata,
	output logic                              pready
);
	import sdm_pkg::*;

	cfg_t             cfg;
	logic             take;
	logic             out_valid_q;
	logic [VecW-1:0]  smoothed_nxt, pulsed_nxt, smoothed_s1, pulsed_s1;
	logic [NormW-1:0] custom_nxt, custom_s1;

	assign in_ready  = ~out_valid_q | out_ready;
	assign take      = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign smoothed_solenoids = smoothed_s1;
	assign pulsed_solenoids   = pulsed_s1;
	assign custom_solenoids   = custom_s1;

	sdm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sdm_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.take             (take),
		.op               (op),
		.data             (data),
		.line_index       (line_index),
		.trigger_switches (trigger_switches),
		.smoothed_nxt     (smoothed_nxt),
		.pulsed_nxt       (pulsed_nxt),
		.custom_nxt       (custom_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			smoothed_s1 <= smoothed_nxt;
			pulsed_s1   <= pulsed_nxt;
			custom_s1   <= custom_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: verif/tb_solenoid_driver_with_mux_smoothing.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_solenoid_driver_with_mux_smoothing: self-checking bench for the driver
// Byte, special-line, enable, tick and direct-low transactions are sent with
// random gaps while the output side stalls at random. A local predictor of
// the solenoid vector, mux latch and two-frame smoothing checks every result.
// Registers are written over the APB port and read back between phases.
// ---------------------------------------------------------------------------

module tb_solenoid_driver_with_mux_smoothing;
	import sdm_pkg::*;

	localparam logic [OpW-1:0] OpSpare6 = 3'd6;
	localparam logic [OpW-1:0] OpSpare7 = 3'd7;
	localparam int CycleLimit = 200000;
	localparam int RandomPhases = 8;
	localparam int PhaseItems = 110;

	typedef struct packed {
		logic [VecW-1:0]  smoothed;
		logic [VecW-1:0]  pulsed;
		logic [NormW-1:0] custom;
	} sol_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [OpW-1:0] op;
	logic [DataW-1:0] data;
	logic [IdxW-1:0] line_index;
	logic [SpecW-1:0] trigger_switches;
	logic out_valid;
	logic out_ready;
	logic [VecW-1:0] smoothed_solenoids;
	logic [VecW-1:0] pulsed_solenoids;
	logic [NormW-1:0] custom_solenoids;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [PdataW-1:0] pwdata;
	logic [PdataW-1:0] prdata;
	logic pready;

	solenoid_driver_with_mux_smoothing u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.data(data),
		.line_index(line_index),
		.trigger_switches(trigger_switches),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.smoothed_solenoids(smoothed_solenoids),
		.pulsed_solenoids(pulsed_solenoids),
		.custom_solenoids(custom_solenoids),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Predicted block state and register copy.
	logic             cfg_alt;
	logic [MuxNumW-1:0] cfg_mux_sol;
	logic [NormW-1:0] cfg_mux_mask;
	logic [SpecW-1:0] cfg_sw_mask;
	logic [DataW-1:0] sol_low;
	logic [DataW-1:0] sol_high;
	logic [VecW-1:0]  sol_pulsed;
	logic [VecW-1:0]  sol_accum;
	logic [VecW-1:0]  sol_history [2];
	logic             sol_parity;
	logic             sol_spec_en;
	logic [NormW-1:0] sol_latch;
	logic [VecW-1:0]  sol_smoothed;

	sol_result_t expected_outputs[$];

	int errors = 0;
	int items_sent = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int settings_used = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	function automatic void rebuild_pulsed();
		logic sel;
		sol_pulsed = (sol_pulsed & KeepSpecial) | VecW'({sol_high, sol_low});
		if (cfg_mux_sol != MuxNone) begin
			sel = (cfg_mux_sol <= MuxBits) ? sol_pulsed[cfg_mux_sol - 1] : 1'b0;
			if (sel) begin
				sol_latch = sol_pulsed[NormW-1:0] & cfg_mux_mask;
				sol_pulsed &= ~VecW'(cfg_mux_mask);
			end else begin
				sol_latch = '0;
			end
		end
		sol_accum |= sol_pulsed;
	endfunction

	function automatic sol_result_t solenoid_predict(input logic [OpW-1:0] code,
			input logic [DataW-1:0] value, input logic [IdxW-1:0] idx,
			input logic [SpecW-1:0] sw);
		logic [VecW-1:0] line_bit;
		logic line_on;
		sol_result_t res;
		case (code)
			OP_LOW_BYTE: begin
				if (value != sol_low) begin
					sol_low = value;
					rebuild_pulsed();
				end
			end
			OP_HIGH_BYTE: begin
				if (value != sol_high) begin
					sol_high = value;
					rebuild_pulsed();
				end
			end
			OP_SPEC_LINE: begin
				line_bit = VecW'(1) << (SpecLsb + idx);
				line_on = cfg_alt ? value[0] : (sol_spec_en && !value[0]);
				if (line_on) begin
					sol_pulsed |= line_bit;
					sol_accum |= line_bit;
				end else begin
					sol_pulsed &= ~line_bit;
				end
			end
			OP_SPEC_ENABLE: sol_spec_en = value[0];
			OP_FRAME_TICK: begin
				sol_parity = ~sol_parity;
				if (cfg_alt || sol_spec_en) begin
					sol_accum |= GameOnBit | (VecW'(sw & cfg_sw_mask) << SpecLsb);
				end
				sol_history[sol_parity] = sol_accum;
				sol_smoothed = sol_history[0] | sol_history[1];
				sol_accum = sol_pulsed;
			end
			OP_DIRECT_LOW: begin
				sol_pulsed = (sol_pulsed & KeepHigh) | VecW'(value);
				sol_accum |= VecW'(value);
			end
			default: ;
		endcase
		res.smoothed = sol_smoothed;
		res.pulsed = sol_pulsed;
		res.custom = sol_latch;
		return res;
	endfunction

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Timeout after %0d cycles, %0d results still pending", cycle_count,
				expected_outputs.size());
			$display("tb_solenoid_driver_with_mux_smoothing NOT OK");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off when a test asks for one.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		sol_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_outputs.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: smoothed %h pulsed %h custom %h",
					$time, smoothed_solenoids, pulsed_solenoids, custom_solenoids);
			end else begin
				want = expected_outputs.pop_front();
				results_checked++;
				if (smoothed_solenoids !== want.smoothed) begin
					errors++;
					$display("%0t: smoothed_solenoids expected %h actual %h", $time,
						want.smoothed, smoothed_solenoids);
				end
				if (pulsed_solenoids !== want.pulsed) begin
					errors++;
					$display("%0t: pulsed_solenoids expected %h actual %h", $time,
						want.pulsed, pulsed_solenoids);
				end
				if (custom_solenoids !== want.custom) begin
					errors++;
					$display("%0t: custom_solenoids expected %h actual %h", $time,
						want.custom, custom_solenoids);
				end
			end
		end
	end

	task automatic send_item(input logic [OpW-1:0] code, input logic [DataW-1:0] value,
			input logic [IdxW-1:0] idx, input logic [SpecW-1:0] sw);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= code;
		data <= value;
		line_index <= idx;
		trigger_switches <= sw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		items_sent++;
		if (code == OP_FRAME_TICK) ticks_sent++;
		expected_outputs.push_back(solenoid_predict(code, value, idx, sw));
	endtask

	// Stops offering and waits until every expected result has been taken.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_outputs.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PdataW-1:0] value);
		logic [PdataW-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_ALT_MODE: cfg_alt = value[0];
			REG_MUX_SOL:  cfg_mux_sol = value[MuxNumW-1:0];
			REG_MUX_MASK: cfg_mux_mask = value[NormW-1:0];
			REG_SW_MASK:  cfg_sw_mask = value[SpecW-1:0];
			default: ;
		endcase
		// Read the register back in a second transfer.
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== value) begin
			errors++;
			$display("%0t: register %s read back expected %h actual %h", $time, idx.name(),
				value, got);
		end
	endtask

	task automatic apply_setting(input logic alt, input logic [MuxNumW-1:0] mux_sol,
			input logic [NormW-1:0] mask, input logic [SpecW-1:0] sw_mask);
		write_reg(REG_ALT_MODE, PdataW'(alt));
		write_reg(REG_MUX_SOL, PdataW'(mux_sol));
		write_reg(REG_MUX_MASK, PdataW'(mask));
		write_reg(REG_SW_MASK, PdataW'(sw_mask));
		settings_used++;
	endtask

	task automatic send_random_item();
		int pick;
		logic [OpW-1:0] code;
		logic [DataW-1:0] value;
		pick = $urandom_range(0, 99);
		if (pick < 20) code = OP_LOW_BYTE;
		else if (pick < 40) code = OP_HIGH_BYTE;
		else if (pick < 60) code = OP_SPEC_LINE;
		else if (pick < 68) code = OP_SPEC_ENABLE;
		else if (pick < 86) code = OP_FRAME_TICK;
		else if (pick < 96) code = OP_DIRECT_LOW;
		else code = pick[0] ? OpSpare7 : OpSpare6;
		value = DataW'($urandom_range(0, 255));
		// Rewriting the current byte must leave everything untouched.
		if ($urandom_range(0, 4) == 0) value = (code == OP_HIGH_BYTE) ? sol_high : sol_low;
		send_item(code, value, IdxW'($urandom_range(0, 7)), SpecW'($urandom_range(0, 255)));
	endtask

	task automatic test_byte_writes();
		gap_pct = 20;
		stall_pct = 20;
		send_item(OpSpare7, 8'h00, 3'd0, 8'h00);
		send_item(OP_LOW_BYTE, 8'hff, 3'd0, 8'h00);
		send_item(OP_LOW_BYTE, 8'hff, 3'd0, 8'h00);
		send_item(OP_HIGH_BYTE, 8'hff, 3'd0, 8'h00);
		send_item(OP_HIGH_BYTE, 8'h00, 3'd0, 8'h00);
		send_item(OP_LOW_BYTE, 8'h00, 3'd0, 8'h00);
		send_item(OP_DIRECT_LOW, 8'haa, 3'd0, 8'h00);
		send_item(OP_DIRECT_LOW, 8'h55, 3'd0, 8'h00);
		send_item(OpSpare6, 8'hff, 3'd7, 8'hff);
		wait_idle();
	endtask

	task automatic test_special_lines();
		send_item(OP_SPEC_ENABLE, 8'h01, 3'd0, 8'h00);
		send_item(OP_SPEC_LINE, 8'h00, 3'd0, 8'h00);
		send_item(OP_SPEC_LINE, 8'hfe, 3'd7, 8'h00);
		send_item(OP_SPEC_LINE, 8'h01, 3'd3, 8'h00);
		send_item(OP_FRAME_TICK, 8'h00, 3'd0, 8'hff);
		send_item(OP_SPEC_ENABLE, 8'hfe, 3'd0, 8'h00);
		send_item(OP_SPEC_LINE, 8'h00, 3'd0, 8'h00);
		send_item(OP_FRAME_TICK, 8'h00, 3'd0, 8'hff);
		wait_idle();
	endtask

	task automatic test_mux_and_alternate();
		apply_setting(1'b1, 5'd16, 16'h00ff, 8'ha5);
		send_item(OP_HIGH_BYTE, 8'h80, 3'd0, 8'h00);
		send_item(OP_LOW_BYTE, 8'hff, 3'd0, 8'h00);
		send_item(OP_HIGH_BYTE, 8'h00, 3'd0, 8'h00);
		send_item(OP_SPEC_LINE, 8'h01, 3'd2, 8'h00);
		send_item(OP_FRAME_TICK, 8'h00, 3'd0, 8'hff);
		wait_idle();
		// A mux number past the vector never selects.
		apply_setting(1'b0, 5'd31, 16'hffff, 8'h00);
		send_item(OP_HIGH_BYTE, 8'h80, 3'd0, 8'h00);
		send_item(OP_LOW_BYTE, 8'h01, 3'd0, 8'h00);
		wait_idle();
	endtask

	task automatic test_random_phases();
		logic alt;
		logic [MuxNumW-1:0] mux_sol;
		logic [NormW-1:0] mask;
		logic [SpecW-1:0] sw_mask;
		for (int p = 0; p < RandomPhases; p++) begin
			case (p)
				0: begin alt = 1'b0; mux_sol = 5'd0;  mask = 16'h0000; sw_mask = 8'hff; end
				1: begin alt = 1'b1; mux_sol = 5'd1;  mask = 16'hffff; sw_mask = 8'h00; end
				2: begin alt = 1'b0; mux_sol = 5'd25; mask = 16'hffff; sw_mask = 8'hff; end
				3: begin alt = 1'b1; mux_sol = 5'd26; mask = 16'hffff; sw_mask = 8'hff; end
				default: begin
					alt = 1'($urandom_range(0, 1));
					case ($urandom_range(0, 3))
						0: mux_sol = 5'd0;
						1: mux_sol = MuxNumW'($urandom_range(17, 25));
						default: mux_sol = MuxNumW'($urandom_range(1, 16));
					endcase
					mask = NormW'($urandom_range(0, 65535));
					sw_mask = SpecW'($urandom_range(0, 255));
				end
			endcase
			apply_setting(alt, mux_sol, mask, sw_mask);
			// The first phase runs with no idling on either side.
			gap_pct = (p == 0) ? 0 : $urandom_range(5, 40);
			stall_pct = (p == 0) ? 0 : $urandom_range(5, 50);
			for (int i = 0; i < PhaseItems; i++) send_random_item();
			wait_idle();
		end
	endtask

	task automatic test_backpressure();
		gap_pct = 0;
		stall_pct = 10;
		hold_request = 120;
		for (int i = 0; i < 40; i++) send_random_item();
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_LOW_BYTE;
		data = '0;
		line_index = '0;
		trigger_switches = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_alt = 1'b0;
		cfg_mux_sol = MuxNone;
		cfg_mux_mask = '0;
		cfg_sw_mask = '0;
		sol_low = '0;
		sol_high = '0;
		sol_pulsed = '0;
		sol_accum = '0;
		sol_history[0] = '0;
		sol_history[1] = '0;
		sol_parity = 1'b0;
		sol_spec_en = 1'b0;
		sol_latch = '0;
		sol_smoothed = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_byte_writes();
		test_special_lines();
		test_mux_and_alternate();
		test_backpressure();
		test_random_phases();

		$display("Sent %0d transactions including %0d frame ticks; checked %0d results.",
			items_sent, ticks_sent, results_checked);
		$display("Register settings applied: %0d, with one long output hold-off.",
			settings_used);
		if (errors == 0 && expected_outputs.size() == 0) begin
			$display("tb_solenoid_driver_with_mux_smoothing OK");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_outputs.size());
			$display("tb_solenoid_driver_with_mux_smoothing NOT OK");
		end
		$finish;
	end

endmodule
